/* src/assert_macros.svh */
// Assertion macros shared by the filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/bw3hp_pkg.sv */
// Shared types and constants of the third-order high-pass filter
package bw3hp_pkg;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [17:0] RATE_RESET = 18'd48000;
	localparam logic [4:0] K_STEPS = 5'd27;
	localparam logic [4:0] Y_STEPS = 5'd23;
	localparam logic signed [32:0] COEF_ONE = 33'sh004000000;

	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_LOAD   = 4'd1,
		OP_PMUL   = 4'd2,
		OP_KLOAD  = 4'd3,
		OP_K2MUL  = 4'd4,
		OP_K2RND  = 4'd5,
		OP_K3MUL  = 4'd6,
		OP_COEF   = 4'd7,
		OP_MULA   = 4'd8,
		OP_MULB   = 4'd9,
		OP_MULC   = 4'd10,
		OP_ACCEND = 4'd11,
		OP_YLOAD  = 4'd12,
		OP_SATCHK = 4'd13,
		OP_FIN    = 4'd14
	} op_t;

	typedef struct packed {
		op_t  op;
		logic dstep;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_over;
		logic out_busy;
	} sts_t;

endpackage

/* src/bw3hp_div.sv */
// Restoring divider, one quotient bit per cycle while step is high
module bw3hp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        step,
	input  logic [59:0] dividend,
	input  logic [29:0] divisor,
	input  logic [4:0]  steps,
	output logic [26:0] quo,
	output logic        done,
	output logic        over
);
	import bw3hp_pkg::*;

	logic [59:0] rem_q;
	logic [59:0] dsh_q;
	logic [26:0] quo_q;
	logic [4:0]  cnt_q;
	logic        ge;

	assign ge   = rem_q >= dsh_q;
	assign done = cnt_q == 5'd0;
	// quotient would not fit in the requested number of bits
	assign over = {1'b0, rem_q} >= {dsh_q, 1'b0};
	assign quo  = quo_q;

	// count the remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (load) begin
			cnt_q <= steps;
		end else if (step && !done) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// subtract the shifted divisor where it fits
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= dividend;
			dsh_q <= {30'd0, divisor} << (steps - 5'd1);
			quo_q <= '0;
		end else if (step && !done) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[25:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end
endmodule

/* src/bw3hp_dp.sv */
// Datapath: history, coefficients, shared multiplier and divider
module bw3hp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bw3hp_pkg::cmd_t     cmd,
	output bw3hp_pkg::sts_t     sts,
	input  logic                sample_rate_we,
	input  logic [17:0]         sample_rate,
	input  logic signed [15:0]  sample_in,
	input  logic [16:0]         cutoff_hz,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [15:0]  sample_out
);
	import bw3hp_pkg::*;

	logic [17:0] rate_q, fs_q, fs_eff;
	logic [16:0] fc_q, half, fc_c;
	logic signed [15:0] x_q, x1_q, x2_q, x3_q;
	logic signed [23:0] y1_q, y2_q, y3_q;
	logic signed [60:0] prod_q, mul_p;
	logic signed [32:0] mul_a;
	logic signed [27:0] mul_b;
	logic [26:0] kq_q, quo;
	logic [27:0] k2_q, k3;
	logic [53:0] r2, r3;
	logic signed [32:0] ek, ek2, ek3, ca, cb, cc, cd;
	logic signed [32:0] ca_q, cb_q, cc_q;
	logic [29:0] d_q;
	logic signed [18:0] ex, ex1, ex2, ex3, num;
	logic signed [59:0] acc_q;
	logic [59:0] mag, div_dvd;
	logic [29:0] div_dvs;
	logic [4:0]  div_steps;
	logic        div_load, div_done, div_over;
	logic        neg_q, sat_q;
	logic [22:0] qy;
	logic signed [23:0] y;
	logic signed [24:0] t;
	logic signed [16:0] sh;
	logic signed [15:0] o;
	logic        out_valid_q;
	logic signed [15:0] out_q;

	// hold the sample rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (sample_rate_we) begin
			rate_q <= sample_rate;
		end
	end

	// clamp the rate and the cutoff
	always_comb begin
		fs_eff = (rate_q < 18'd2) ? 18'd2 : rate_q;
		half   = fs_eff[17:1];
		if (cutoff_hz == 17'd0) begin
			fc_c = 17'd1;
		end else if (cutoff_hz > half) begin
			fc_c = half;
		end else begin
			fc_c = cutoff_hz;
		end
	end

	// select the multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_PMUL: begin
				mul_a = $signed({1'b0, PI_Q30});
				mul_b = $signed({11'd0, fc_q});
			end
			OP_K2MUL: begin
				mul_a = $signed({6'd0, quo});
				mul_b = $signed({1'b0, quo});
			end
			OP_K3MUL: begin
				mul_a = $signed({5'd0, k2_q});
				mul_b = $signed({1'b0, kq_q});
			end
			OP_MULA: begin
				mul_a = ca_q;
				mul_b = {{4{y3_q[23]}}, y3_q};
			end
			OP_MULB: begin
				mul_a = cb_q;
				mul_b = {{4{y2_q[23]}}, y2_q};
			end
			OP_MULC: begin
				mul_a = cc_q;
				mul_b = {{4{y1_q[23]}}, y1_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// round k squared and k cubed back to Q2.26
	assign r2 = prod_q[53:0] + (54'd1 << 25);
	assign r3 = prod_q[53:0] + (54'd1 << 25);
	assign k3 = r3[53:26];

	// coefficients from the powers of k
	always_comb begin
		ek  = $signed({6'd0, kq_q});
		ek2 = $signed({5'd0, k2_q});
		ek3 = $signed({5'd0, k3});
		ca  = ek3 - (ek2 <<< 1) + (ek <<< 1) - COEF_ONE;
		cb  = (ek3 <<< 1) + ek3 - (ek2 <<< 1) - (ek <<< 1) + (COEF_ONE <<< 1) + COEF_ONE;
		cc  = (ek3 <<< 1) + ek3 + (ek2 <<< 1) - (ek <<< 1) - (COEF_ONE <<< 1) - COEF_ONE;
		cd  = ek3 + (ek2 <<< 1) + (ek <<< 1) + COEF_ONE;
	end

	// input difference term
	always_comb begin
		ex  = {{3{x_q[15]}}, x_q};
		ex1 = {{3{x1_q[15]}}, x1_q};
		ex2 = {{3{x2_q[15]}}, x2_q};
		ex3 = {{3{x3_q[15]}}, x3_q};
		num = ex - (ex1 <<< 1) - ex1 + (ex2 <<< 1) + ex2 - ex3;
	end

	// divider operands
	always_comb begin
		mag = acc_q[59] ? 60'(-acc_q) : 60'(acc_q);
		if (cmd.op == OP_KLOAD) begin
			div_dvd   = {11'd0, prod_q[48:0]} + {39'd0, fs_q, 3'd0};
			div_dvs   = {8'd0, fs_q, 4'd0};
			div_steps = K_STEPS;
		end else begin
			div_dvd   = mag + {31'd0, d_q[29:1]};
			div_dvs   = d_q;
			div_steps = Y_STEPS;
		end
	end
	assign div_load = (cmd.op == OP_KLOAD) || (cmd.op == OP_YLOAD);

	bw3hp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.step     (cmd.dstep),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.quo      (quo),
		.done     (div_done),
		.over     (div_over)
	);

	// new output history and rounded output sample
	always_comb begin
		qy = quo[22:0];
		if (sat_q) begin
			y = neg_q ? 24'sh800000 : 24'sh7FFFFF;
		end else begin
			y = neg_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		end
		t  = {y[23], y} + 25'sd128;
		sh = t[24:8];
		if (sh[16] != sh[15]) begin
			o = sh[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			o = sh[15:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				fs_q <= fs_eff;
				fc_q <= fc_c;
				x_q  <= sample_in;
			end
			OP_PMUL, OP_K2MUL, OP_K3MUL, OP_MULA: begin
				prod_q <= mul_p;
				if (cmd.op == OP_K2MUL) begin
					kq_q <= quo;
				end
			end
			OP_K2RND: begin
				k2_q <= r2[53:26];
			end
			OP_COEF: begin
				ca_q  <= ca;
				cb_q  <= cb;
				cc_q  <= cc;
				d_q   <= cd[29:0];
				acc_q <= {{7{num[18]}}, num, 34'd0};
			end
			OP_MULB, OP_MULC: begin
				prod_q <= mul_p;
				acc_q  <= acc_q - prod_q[59:0];
			end
			OP_ACCEND: begin
				acc_q <= acc_q - prod_q[59:0];
			end
			OP_YLOAD: begin
				neg_q <= acc_q[59];
			end
			OP_SATCHK: begin
				sat_q <= div_over;
			end
			OP_FIN: begin
				out_q <= o;
			end
			default: begin
			end
		endcase
	end

	// shift the filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			x3_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
			y3_q <= '0;
		end else if (cmd.op == OP_FIN) begin
			x1_q <= x_q;
			x2_q <= x1_q;
			x3_q <= x2_q;
			y1_q <= y;
			y2_q <= y1_q;
			y3_q <= y2_q;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FIN) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = out_q;
	assign sts.div_done = div_done;
	assign sts.div_over = div_over;
	assign sts.out_busy = out_valid_q & ~out_ready;
endmodule

/* src/bw3hp_ctrl.sv */
// Controller: sequences one item through the datapath
module bw3hp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bw3hp_pkg::sts_t sts,
	output bw3hp_pkg::cmd_t cmd
);
	import bw3hp_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_PMUL   = 16'h0002,
		S_KLOAD  = 16'h0004,
		S_KDIV   = 16'h0008,
		S_K2MUL  = 16'h0010,
		S_K2RND  = 16'h0020,
		S_K3MUL  = 16'h0040,
		S_COEF   = 16'h0080,
		S_MULA   = 16'h0100,
		S_MULB   = 16'h0200,
		S_MULC   = 16'h0400,
		S_ACCEND = 16'h0800,
		S_YLOAD  = 16'h1000,
		S_SATCHK = 16'h2000,
		S_YDIV   = 16'h4000,
		S_FIN    = 16'h8000
	} state_t;

	state_t state_q, state_d;

	// next state and command
	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.dstep = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_PMUL;
				end
			end
			S_PMUL: begin
				cmd.op  = OP_PMUL;
				state_d = S_KLOAD;
			end
			S_KLOAD: begin
				cmd.op  = OP_KLOAD;
				state_d = S_KDIV;
			end
			S_KDIV: begin
				if (sts.div_done) begin
					state_d = S_K2MUL;
				end else begin
					cmd.dstep = 1'b1;
				end
			end
			S_K2MUL: begin
				cmd.op  = OP_K2MUL;
				state_d = S_K2RND;
			end
			S_K2RND: begin
				cmd.op  = OP_K2RND;
				state_d = S_K3MUL;
			end
			S_K3MUL: begin
				cmd.op  = OP_K3MUL;
				state_d = S_COEF;
			end
			S_COEF: begin
				cmd.op  = OP_COEF;
				state_d = S_MULA;
			end
			S_MULA: begin
				cmd.op  = OP_MULA;
				state_d = S_MULB;
			end
			S_MULB: begin
				cmd.op  = OP_MULB;
				state_d = S_MULC;
			end
			S_MULC: begin
				cmd.op  = OP_MULC;
				state_d = S_ACCEND;
			end
			S_ACCEND: begin
				cmd.op  = OP_ACCEND;
				state_d = S_YLOAD;
			end
			S_YLOAD: begin
				cmd.op  = OP_YLOAD;
				state_d = S_SATCHK;
			end
			S_SATCHK: begin
				cmd.op  = OP_SATCHK;
				state_d = sts.div_over ? S_FIN : S_YDIV;
			end
			S_YDIV: begin
				if (sts.div_done) begin
					state_d = S_FIN;
				end else begin
					cmd.dstep = 1'b1;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_IDLE;
endmodule

/* src/butterworth3_highpass_variable_cutoff.sv */
// Top level of the third-order Butterworth high-pass filter with per-item cutoff
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------
//  input     | in_valid / in_ready       | sample_in[15:0], cutoff_hz[16:0]
//  output    | out_valid / out_ready     | sample_out[15:0]
//  config    | sample_rate_we            | sample_rate[17:0]
//
// An item is accepted only while the controller is idle, so the block does not take a
// new item before the last one has reached the output register. The bit-serial divider
// (27 steps for k, 23 for the output) and the single shared multiplier do the work; when
// the quotient saturates, the output division is skipped.
// A finished item waits in the output register while the next one is
// worked on; it only stalls at the final step if that register is still full.
// Reset clears the history, the controller and the output valid flag; the
// sample rate returns to 48000.
module butterworth3_highpass_variable_cutoff (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_in,
	input  logic [16:0]        cutoff_hz,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out,
	input  logic               sample_rate_we,
	input  logic [17:0]        sample_rate
);
	import bw3hp_pkg::*;
	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	bw3hp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bw3hp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample_rate_we (sample_rate_we),
		.sample_rate    (sample_rate),
		.sample_in      (sample_in),
		.cutoff_hz      (cutoff_hz),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.sample_out     (sample_out)
	);

	// an accepted item starts with the frequency product
	`ASSERT_NEXT(a_start, clk, arst_n, in_valid && in_ready, cmd.op == OP_PMUL, "item did not start")
	// never overwrite a result that is still waiting
	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.op == OP_FIN, !(out_valid && !out_ready), "result overwritten")
	// the divider is only stepped while it has work left
	`ASSERT_IMPLY(a_div_step, clk, arst_n, cmd.dstep, !sts.div_done, "divider stepped when done")
endmodule

/* sim/tb_butterworth3_highpass_variable_cutoff.sv */
// Testbench for the third-order Butterworth high-pass filter with per-item cutoff
`timescale 1ns / 1ps

module tb_butterworth3_highpass_variable_cutoff;
	import bw3hp_pkg::*;

	localparam int N_DIRECTED_MAX = 25;
	localparam int N_RANDOM = 1530;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam longint unsigned PI_FIX = 64'd3373259426;
	localparam int COEF_FRAC = 26;

	// Scoreboard: tracks filter state and queues the predicted output samples
	class hp_scoreboard;
		longint signed x_hist[3];
		longint signed y_hist[3];
		longint unsigned fs_hz;
		logic signed [15:0] pending_q[$];
		int n_errors;

		function void clear();
			for (int i = 0; i < 3; i++) begin
				x_hist[i] = 0;
				y_hist[i] = 0;
			end
			fs_hz = 48000;
			n_errors = 0;
			pending_q.delete();
		endfunction

		function void set_rate(logic [17:0] v);
			fs_hz = 64'(v);
		endfunction

		function longint unsigned fix_mul(longint unsigned p, longint unsigned q);
			return (p * q + (64'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
		endfunction

		// Predict one filtered sample and advance the history
		function void note_item(logic signed [15:0] smp, logic [16:0] cut);
			longint signed one, x, k, k2, k3, ca, cb, cc, cd, num, acc, y, o, hi, lo;
			longint unsigned fs, fc, mag, q, t;
			one = 64'sd1 <<< COEF_FRAC;
			fs = fs_hz;
			fc = 64'(cut);
			if (fs < 2)
				fs = 2;
			if (fc < 1)
				fc = 1;
			if (fc > fs / 2)
				fc = fs / 2;
			x = longint'(smp);
			k = (PI_FIX * fc + (fs << 3)) / (fs << 4);
			k2 = fix_mul(k, k);
			k3 = fix_mul(k2, k);
			ca = k3 - 2 * k2 + 2 * k - one;
			cb = 3 * k3 - 2 * k2 - 2 * k + 3 * one;
			cc = 3 * k3 + 2 * k2 - 2 * k - 3 * one;
			cd = k3 + 2 * k2 + 2 * k + one;
			num = x - 3 * x_hist[0] + 3 * x_hist[1] - x_hist[2];
			acc = num * 256 * one - (ca * y_hist[2] + cb * y_hist[1] + cc * y_hist[0]);
			mag = (acc < 0) ? -acc : acc;
			q = (mag + cd / 2) / cd;
			y = (acc < 0) ? -longint'(q) : longint'(q);
			hi = (64'sd1 <<< 23) - 1;
			lo = -hi - 1;
			if (y > hi)
				y = hi;
			else if (y < lo)
				y = lo;
			t = y + (64'd1 << 23) + 128;
			o = longint'(t >> 8) - 32768;
			if (o > 32767)
				o = 32767;
			else if (o < -32768)
				o = -32768;
			x_hist[2] = x_hist[1];
			x_hist[1] = x_hist[0];
			x_hist[0] = x;
			y_hist[2] = y_hist[1];
			y_hist[1] = y_hist[0];
			y_hist[0] = y;
			pending_q.push_back(o[15:0]);
		endfunction

		function void check_result(logic signed [15:0] got);
			logic signed [15:0] want;
			if (pending_q.size() == 0) begin
				$error("sample_out: unexpected output %0d", got);
				n_errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got !== want) begin
				$error("sample_out: expected %0d, actual %0d", want, got);
				n_errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] sample_in;
	logic [16:0] cutoff_hz;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] sample_out;
	logic sample_rate_we;
	logic [17:0] sample_rate;

	hp_scoreboard sb;
	bit no_idle;
	bit stim_done;
	int quiet_cycles;

	butterworth3_highpass_variable_cutoff dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.cutoff_hz(cutoff_hz),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.sample_rate_we(sample_rate_we),
		.sample_rate(sample_rate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one item and hold it until accepted
	task automatic send_item(logic signed [15:0] smp, logic [16:0] cut);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= smp;
		cutoff_hz <= cut;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(smp, cut);
		@(negedge clk);
	endtask

	// Wait for every expected sample, then let the block settle before a write
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	task automatic write_rate(logic [17:0] v);
		wait_idle();
		sample_rate_we <= 1'b1;
		sample_rate <= v;
		@(negedge clk);
		sample_rate_we <= 1'b0;
		sb.set_rate(v);
	endtask

	// Random sample with a bias towards full scale
	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [16:0] rand_cutoff();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'h1FFFF;
			2: return 17'($urandom_range(1, 200));
			3: return 17'($urandom_range(90000, 131071));
			default: return 17'($urandom_range(20, 24000));
		endcase
	endfunction

	task automatic random_block(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_sample(), rand_cutoff());
	endtask

	// Receiver: random back-pressure bursts, none in the last part
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!no_idle && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(sample_out);

	// Watchdog on cycles without any accepted item or taken result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n_dir;
		sb = new();
		sb.clear();
		no_idle = 1'b0;
		stim_done = 1'b0;
		quiet_cycles = 0;
		in_valid = 1'b0;
		sample_in = '0;
		cutoff_hz = '0;
		sample_rate_we = 1'b0;
		sample_rate = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: full-scale steps, cutoff clamps at both ends, impulse
		n_dir = 0;
		send_item(16'sh7FFF, 17'd0);
		send_item(16'sh8000, 17'd1);
		send_item(16'sh7FFF, 17'h1FFFF);
		send_item(16'sh8000, 17'd24000);
		send_item(16'sh7FFF, 17'd24001);
		send_item(16'sh8000, 17'd96000);
		send_item(16'sh0000, 17'd1000);
		send_item(16'sh0001, 17'd1000);
		send_item(16'shFFFF, 17'd50);
		for (int i = 0; i < 6; i++)
			send_item(i[0] ? 16'sh8000 : 16'sh7FFF, 17'd20);
		n_dir = 15;
		write_rate(18'd0);
		send_item(16'sh7FFF, 17'd5);
		send_item(16'sh8000, 17'd0);
		write_rate(18'd1);
		send_item(16'sh4000, 17'd1);
		write_rate(18'h3FFFF);
		send_item(16'sh8000, 17'h1FFFF);
		send_item(16'sh7FFF, 17'd100);
		n_dir += 5;
		if (n_dir > N_DIRECTED_MAX)
			$display("directed part longer than planned");

		// Random across several sample rates
		write_rate(18'd8000);
		random_block(300);
		write_rate(18'd192000);
		random_block(300);
		write_rate(18'd44100);
		random_block(300);
		write_rate(18'($urandom_range(0, 18'h3FFFF)));
		random_block(280);
		write_rate(18'd48000);
		random_block(200);
		no_idle = 1'b1;
		random_block(150);

		in_valid <= 1'b0;
		stim_done = 1'b1;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// End-of-run drain limit
	initial begin
		wait (stim_done);
		repeat (20000) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
